>>> rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Command, status and return codes, sequencer states and the default word width.
// ----------------------------------------------------------------------------
package rau_pkg;

	// default word width of numerators (b and result denominators are one bit narrower)
	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_MUL   = 3'd2,
		CMD_DIV   = 3'd3,
		CMD_NEG   = 3'd4,
		CMD_RECIP = 3'd5,
		CMD_ROUND = 3'd6,
		CMD_NORM  = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	// where the reduce sequence hands its result
	typedef enum logic [1:0] {
		RET_A = 2'd0,
		RET_B = 2'd1,
		RET_R = 2'd2
	} ret_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RED_GCD_GO,
		S_RED_GCD_WAIT,
		S_RED_DM_GO,
		S_RED_DM_WAIT,
		S_RED_DK_GO,
		S_RED_DK_WAIT,
		S_RED_CHK,
		S_DISPATCH,
		S_ADD_GCD_GO,
		S_ADD_GCD_WAIT,
		S_ADD_DA_GO,
		S_ADD_DA_WAIT,
		S_ADD_DB_GO,
		S_ADD_DB_WAIT,
		S_ADD_M1,
		S_ADD_M2,
		S_ADD_M3,
		S_ADD_SUM,
		S_MUL_M1,
		S_MUL_M2,
		S_MUL_CHK,
		S_RND_GO,
		S_RND_WAIT,
		S_RND_FIN,
		S_FIN
	} state_t;

endpackage

>>> rtl/core/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd: iterative binary gcd
// One compare/subtract/shift step per cycle; result held until next start.
// ----------------------------------------------------------------------------
module rau_gcd #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	output logic [W-1:0] g,
	output logic         done
);

	localparam int SW = $clog2(W);

	logic [W-1:0]  x_q, y_q, g_q;
	logic [SW-1:0] sh_q;
	logic          busy_q, done_q;
	logic          fin;

	assign fin  = (x_q == '0) || (y_q == '0);
	assign g    = g_q;
	assign done = done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && fin) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one binary gcd step
	always_ff @(posedge clk) begin
		if (start) begin
			x_q  <= x;
			y_q  <= y;
			sh_q <= '0;
		end else if (busy_q) begin
			if (fin) begin
				g_q <= (x_q | y_q) << sh_q;
			end else if (!x_q[0] && !y_q[0]) begin
				x_q  <= x_q >> 1;
				y_q  <= y_q >> 1;
				sh_q <= sh_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= (x_q - y_q) >> 1;
			end else begin
				y_q <= (y_q - x_q) >> 1;
			end
		end
	end

endmodule

>>> rtl/core/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div: restoring unsigned divider
// One quotient bit per cycle; quotient and remainder held after done.
// ----------------------------------------------------------------------------
module rau_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] n,
	input  logic [W-1:0] d,
	output logic [W-1:0] q,
	output logic [W-1:0] r,
	output logic         done
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign q     = quo_q;
	assign r     = rem_q;
	assign done  = done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-subtract step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= n;
			den_q <= d;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

endmodule

>>> rtl/core/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, sub, mul, div, negate, reciprocal, round and
// normalize on reduced rationals, one transaction at a time.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries cmd and two rationals; the output
// channel (out_valid/out_stall) returns one reduced result and a status per
// transaction. A transaction is taken when valid is high and stall is low.
// in_stall stays high while a transaction is being worked on; the finished
// result sits in an output register, so the next transaction may enter while
// the receiver still stalls the previous result. A result that finishes while
// that register is still full and stalled waits, and in_stall stays high.
// The run time is set by the shared binary gcd and the restoring divider:
// each reduction costs one gcd run plus two divisions, the divisions skipped
// when the gcd is one. An add runs up to three reductions, one extra gcd and
// two extra divisions; a mul or div three reductions and two products.
// Reset clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           cmd,
	input  logic [WORD_BITS-1:0] a_num,
	input  logic [WORD_BITS-1:0] a_den,
	input  logic [WORD_BITS-1:0] b_num,
	input  logic [WORD_BITS-2:0] b_den,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_BITS-1:0] res_num,
	output logic [WORD_BITS-2:0] res_den,
	output logic [1:0]           status
);

	localparam int W  = WORD_BITS;
	localparam int PW = 2 * W + 2;
	localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

	state_t state_q, state_d;

	// operand and result registers
	cmd_t            cmd_q;
	status_t         status_q;
	logic [W-1:0]    an_q, bn_q, rn_q;
	logic [W-2:0]    ad_q, bd_q, rd_q, p_q, q_q;
	logic signed [PW-1:0] pa_q, pb_q, pc_q;

	// reduce registers
	logic            red_neg_q;
	logic [W-1:0]    red_m_q, red_k_q;
	ret_t            ret_q;

	// output register
	logic            out_valid_q;
	logic [W-1:0]    res_num_q;
	logic [W-2:0]    res_den_q;
	status_t         res_st_q;

	// sequencer controls
	logic            red_ld;
	logic [W-1:0]    red_n, red_d;
	ret_t            red_ret;
	logic            set_st;
	status_t         st_val;
	logic            gcd_go, div_go, fin_ld;
	logic [W-1:0]    gcd_x, gcd_y, gcd_g;
	logic            gcd_done;
	logic [W-1:0]    div_n, div_d, div_qo, div_ro;
	logic            div_done;
	logic signed [W:0] mul_x, mul_y;
	logic signed [PW-1:0] prod;

	// helpers
	logic            accept, red_nz, red_ok;
	logic [W-1:0]    rv_n;
	logic [PW:0]     sum_w;
	logic            sum_ok, pa_ok, pb_ok;
	logic            an_min, bn_min, an_zero, bn_zero;
	logic [W-1:0]    an_mag, bn_mag, red_n_mag, red_d_mag, rnd_mag;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign red_nz    = (red_d != '0);
	assign red_n_mag = red_n[W-1] ? W'(-red_n) : red_n;
	assign red_d_mag = red_d[W-1] ? W'(-red_d) : red_d;

	// reduced value fits when denominator < 2^(W-1), numerator up to 2^(W-1) if negative
	assign red_ok = !red_k_q[W-1] && (!red_m_q[W-1] || (red_neg_q && red_m_q == MIN_VAL));
	assign rv_n   = red_neg_q ? W'(-red_m_q) : red_m_q;

	assign an_min  = (an_q == MIN_VAL);
	assign bn_min  = (bn_q == MIN_VAL);
	assign an_zero = (an_q == '0);
	assign bn_zero = (bn_q == '0);
	assign an_mag  = an_q[W-1] ? W'(-an_q) : an_q;
	assign bn_mag  = bn_q[W-1] ? W'(-bn_q) : bn_q;

	// range checks: top bits all copies of bit W-1
	assign sum_w  = {pb_q[PW-1], pb_q} + {pc_q[PW-1], pc_q};
	assign sum_ok = (&sum_w[PW:W-1]) || !(|sum_w[PW:W-1]);
	assign pa_ok  = (&pa_q[PW-1:W-1]) || !(|pa_q[PW-1:W-1]);
	assign pb_ok  = (&pb_q[PW-1:W-1]) || !(|pb_q[PW-1:W-1]);

	// rounding: step away from zero when twice the remainder exceeds the denominator
	assign rnd_mag = div_qo + W'({div_ro[W-2:0], 1'b0} > {1'b0, ad_q});

	// shared multiplier
	assign prod = mul_x * mul_y;

	rau_gcd #(.W(W)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_go),
		.x      (gcd_x),
		.y      (gcd_y),
		.g      (gcd_g),
		.done   (gcd_done)
	);

	rau_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.n      (div_n),
		.d      (div_d),
		.q      (div_qo),
		.r      (div_ro),
		.done   (div_done)
	);

	// sequencer outputs
	always_comb begin
		red_ld  = 1'b0;
		red_n   = '0;
		red_d   = '0;
		red_ret = RET_A;
		set_st  = 1'b0;
		st_val  = ST_OK;
		gcd_go  = 1'b0;
		gcd_x   = red_m_q;
		gcd_y   = red_k_q;
		div_go  = 1'b0;
		div_n   = '0;
		div_d   = '0;
		mul_x   = '0;
		mul_y   = '0;
		fin_ld  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					red_ld  = 1'b1;
					red_n   = a_num;
					red_d   = a_den;
					red_ret = RET_A;
				end
			end
			S_RED_GCD_GO: gcd_go = 1'b1;
			S_RED_DM_GO: begin
				div_go = 1'b1;
				div_n  = red_m_q;
				div_d  = gcd_g;
			end
			S_RED_DK_GO: begin
				div_go = 1'b1;
				div_n  = red_k_q;
				div_d  = gcd_g;
			end
			S_RED_CHK: begin
				if (!red_ok) begin
					set_st = 1'b1;
					st_val = ST_OVF;
				end else if (ret_q == RET_A &&
						(cmd_q inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV})) begin
					red_ld  = 1'b1;
					red_n   = bn_q;
					red_d   = {1'b0, bd_q};
					red_ret = RET_B;
				end
			end
			S_DISPATCH: begin
				unique case (cmd_q)
					CMD_SUB: begin
						if (bn_min) begin
							set_st = 1'b1;
							st_val = ST_OVF;
						end
					end
					CMD_DIV: begin
						if (bn_zero) begin
							set_st = 1'b1;
							st_val = ST_DIV0;
						end else if (bn_min) begin
							set_st = 1'b1;
							st_val = ST_OVF;
						end
					end
					CMD_NEG: begin
						if (an_min) begin
							set_st = 1'b1;
							st_val = ST_OVF;
						end
					end
					CMD_RECIP: begin
						if (an_zero) begin
							set_st = 1'b1;
							st_val = ST_DIV0;
						end else if (an_min) begin
							set_st = 1'b1;
							st_val = ST_OVF;
						end
					end
					CMD_ADD, CMD_MUL, CMD_ROUND, CMD_NORM: ;
					default: ;
				endcase
			end
			S_ADD_GCD_GO: begin
				gcd_go = 1'b1;
				gcd_x  = {1'b0, ad_q};
				gcd_y  = {1'b0, bd_q};
			end
			S_ADD_DA_GO: begin
				div_go = 1'b1;
				div_n  = {1'b0, ad_q};
				div_d  = gcd_g;
			end
			S_ADD_DB_GO: begin
				div_go = 1'b1;
				div_n  = {1'b0, bd_q};
				div_d  = gcd_g;
			end
			S_ADD_M1: begin
				mul_x = $signed({2'b00, p_q});
				mul_y = $signed({2'b00, bd_q});
			end
			S_ADD_M2: begin
				mul_x = $signed({bn_q[W-1], bn_q});
				mul_y = $signed({2'b00, p_q});
			end
			S_ADD_M3: begin
				mul_x = $signed({an_q[W-1], an_q});
				mul_y = $signed({2'b00, q_q});
			end
			S_ADD_SUM: begin
				if (sum_ok && pa_ok) begin
					red_ld  = 1'b1;
					red_n   = sum_w[W-1:0];
					red_d   = pa_q[W-1:0];
					red_ret = RET_R;
				end else begin
					set_st = 1'b1;
					st_val = ST_OVF;
				end
			end
			S_MUL_M1: begin
				mul_x = $signed({2'b00, ad_q});
				mul_y = $signed({2'b00, bd_q});
			end
			S_MUL_M2: begin
				mul_x = $signed({an_q[W-1], an_q});
				mul_y = $signed({bn_q[W-1], bn_q});
			end
			S_MUL_CHK: begin
				if (pb_ok && pa_ok) begin
					red_ld  = 1'b1;
					red_n   = pb_q[W-1:0];
					red_d   = pa_q[W-1:0];
					red_ret = RET_R;
				end else begin
					set_st = 1'b1;
					st_val = ST_OVF;
				end
			end
			S_RND_GO: begin
				div_go = 1'b1;
				div_n  = an_mag;
				div_d  = {1'b0, ad_q};
			end
			S_FIN: fin_ld = !out_valid_q || !out_stall;
			default: ;
		endcase
		// zero denominator on any reduction
		if (red_ld && !red_nz) begin
			set_st = 1'b1;
			st_val = ST_DIV0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:         if (red_ld) state_d = red_nz ? S_RED_GCD_GO : S_FIN;
			S_RED_GCD_GO:   state_d = S_RED_GCD_WAIT;
			S_RED_GCD_WAIT: begin
				if (gcd_done) state_d = (gcd_g == W'(1)) ? S_RED_CHK : S_RED_DM_GO;
			end
			S_RED_DM_GO:    state_d = S_RED_DM_WAIT;
			S_RED_DM_WAIT:  if (div_done) state_d = S_RED_DK_GO;
			S_RED_DK_GO:    state_d = S_RED_DK_WAIT;
			S_RED_DK_WAIT:  if (div_done) state_d = S_RED_CHK;
			S_RED_CHK: begin
				if (!red_ok) begin
					state_d = S_FIN;
				end else begin
					unique case (ret_q)
						RET_A: begin
							if (red_ld) state_d = red_nz ? S_RED_GCD_GO : S_FIN;
							else state_d = S_DISPATCH;
						end
						RET_B:   state_d = S_DISPATCH;
						RET_R:   state_d = S_FIN;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_DISPATCH: begin
				unique case (cmd_q)
					CMD_ADD:   state_d = S_ADD_GCD_GO;
					CMD_SUB:   state_d = set_st ? S_FIN : S_ADD_GCD_GO;
					CMD_MUL:   state_d = S_MUL_M1;
					CMD_DIV:   state_d = set_st ? S_FIN : S_MUL_M1;
					CMD_ROUND: state_d = S_RND_GO;
					CMD_NEG, CMD_RECIP, CMD_NORM: state_d = S_FIN;
					default:   state_d = S_FIN;
				endcase
			end
			S_ADD_GCD_GO:   state_d = S_ADD_GCD_WAIT;
			S_ADD_GCD_WAIT: begin
				if (gcd_done) state_d = (gcd_g == W'(1)) ? S_ADD_M1 : S_ADD_DA_GO;
			end
			S_ADD_DA_GO:    state_d = S_ADD_DA_WAIT;
			S_ADD_DA_WAIT:  if (div_done) state_d = S_ADD_DB_GO;
			S_ADD_DB_GO:    state_d = S_ADD_DB_WAIT;
			S_ADD_DB_WAIT:  if (div_done) state_d = S_ADD_M1;
			S_ADD_M1:       state_d = S_ADD_M2;
			S_ADD_M2:       state_d = S_ADD_M3;
			S_ADD_M3:       state_d = S_ADD_SUM;
			S_ADD_SUM:      state_d = red_ld ? S_RED_GCD_GO : S_FIN;
			S_MUL_M1:       state_d = S_MUL_M2;
			S_MUL_M2:       state_d = S_MUL_CHK;
			S_MUL_CHK:      state_d = red_ld ? S_RED_GCD_GO : S_FIN;
			S_RND_GO:       state_d = S_RND_WAIT;
			S_RND_WAIT:     if (div_done) state_d = S_RND_FIN;
			S_RND_FIN:      state_d = S_FIN;
			S_FIN:          if (fin_ld) state_d = S_IDLE;
			default:        state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_ld) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			bn_q  <= b_num;
			bd_q  <= b_den;
		end

		if (set_st) status_q <= st_val;
		else if (accept) status_q <= ST_OK;

		// load a reduction
		if (red_ld && red_nz) begin
			red_neg_q <= (red_n != '0) && (red_n[W-1] != red_d[W-1]);
			red_m_q   <= red_n_mag;
			red_k_q   <= red_d_mag;
			ret_q     <= red_ret;
		end

		unique case (state_q)
			S_RED_DM_WAIT: if (div_done) red_m_q <= div_qo;
			S_RED_DK_WAIT: if (div_done) red_k_q <= div_qo;
			S_RED_CHK: begin
				if (red_ok) begin
					unique case (ret_q)
						RET_A: begin
							an_q <= rv_n;
							ad_q <= red_k_q[W-2:0];
						end
						RET_B: begin
							bn_q <= rv_n;
							bd_q <= red_k_q[W-2:0];
						end
						RET_R: begin
							rn_q <= rv_n;
							rd_q <= red_k_q[W-2:0];
						end
						default: ;
					endcase
				end
			end
			S_DISPATCH: begin
				unique case (cmd_q)
					CMD_SUB: bn_q <= W'(-bn_q);
					CMD_DIV: begin
						// b is reduced, so 1/b needs no further reduction
						bn_q <= bn_q[W-1] ? W'(-{1'b0, bd_q}) : {1'b0, bd_q};
						bd_q <= bn_mag[W-2:0];
					end
					CMD_NEG: begin
						rn_q <= W'(-an_q);
						rd_q <= ad_q;
					end
					CMD_RECIP: begin
						rn_q <= an_q[W-1] ? W'(-{1'b0, ad_q}) : {1'b0, ad_q};
						rd_q <= an_mag[W-2:0];
					end
					CMD_NORM: begin
						rn_q <= an_q;
						rd_q <= ad_q;
					end
					CMD_ADD, CMD_MUL, CMD_ROUND: ;
					default: ;
				endcase
			end
			S_ADD_GCD_WAIT: begin
				if (gcd_done) begin
					p_q <= ad_q;
					q_q <= bd_q;
				end
			end
			S_ADD_DA_WAIT: if (div_done) p_q <= div_qo[W-2:0];
			S_ADD_DB_WAIT: if (div_done) q_q <= div_qo[W-2:0];
			S_ADD_M1:      pa_q <= prod;
			S_ADD_M2:      pb_q <= prod;
			S_ADD_M3:      pc_q <= prod;
			S_MUL_M1:      pa_q <= prod;
			S_MUL_M2:      pb_q <= prod;
			S_RND_FIN: begin
				rn_q <= an_q[W-1] ? W'(-rnd_mag) : rnd_mag;
				rd_q <= (W-1)'(1);
			end
			default: ;
		endcase

		// output register; errors return 0/1
		if (fin_ld) begin
			res_st_q  <= status_q;
			res_num_q <= (status_q == ST_OK) ? rn_q : '0;
			res_den_q <= (status_q == ST_OK) ? rd_q : (W-1)'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign status    = res_st_q;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for rational_arithmetic_unit
// Drives directed corner cases and random commands and operands, predicts each
// reduced result and status with a behavioral model, and checks every output
// transaction in order under random idling, a long output hold-off and a drain.
// ----------------------------------------------------------------------------
module tb_top;
	import rau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB = 32;
	localparam int WDOG_LIMIT = 20000;
	localparam longint LO = -(64'sd1 <<< (WB - 1));
	localparam longint HI = (64'sd1 <<< (WB - 1)) - 1;
	localparam logic [WB-1:0] W_MIN = 32'h8000_0000;
	localparam logic [WB-1:0] W_MAX = 32'h7FFF_FFFF;

	typedef struct {
		cmd_t          opc;
		logic [WB-1:0] an, ad, bn;
		logic [WB-2:0] bd;
	} op_t;

	typedef struct {
		logic [WB-1:0] num;
		logic [WB-2:0] den;
		status_t       st;
	} frac_res_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [2:0]    cmd = '0;
	logic [WB-1:0] a_num = '0, a_den = '0, b_num = '0;
	logic [WB-2:0] b_den = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [WB-1:0] res_num;
	logic [WB-2:0] res_den;
	logic [1:0]    status;

	op_t       op_queue[$];
	frac_res_t pending_results[$];
	int        errors = 0;
	bit        quiet = 0;
	int        hold_seq = 0;

	rational_arithmetic_unit #(.WORD_BITS(WB)) DUT (.*);

	always #2 clk = ~clk;

	// ---------------- arithmetic model ----------------
	function automatic longint unsigned mag(longint v);
		return v < 0 ? 64'd0 - longint'(v) : v;
	endfunction

	function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// reduce n/d with the sign on the numerator
	function automatic status_t reduce_frac(longint n, longint d, output longint rn,
			output longint rd);
		longint unsigned m, k, g;
		bit neg;
		rn = 0;
		rd = 1;
		if (d == 0) return ST_DIV0;
		neg = (n != 0) && ((n < 0) != (d < 0));
		m = mag(n);
		k = mag(d);
		g = gcd64(m, k);
		m = m / g;
		k = k / g;
		if (k > HI) return ST_OVF;
		if (m > HI + (neg ? 1 : 0)) return ST_OVF;
		rn = neg ? -longint'(m) : longint'(m);
		rd = longint'(k);
		return ST_OK;
	endfunction

	function automatic bit fits(longint v);
		return v >= LO && v <= HI;
	endfunction

	function automatic status_t add_frac(longint an, longint ad, longint bn, longint bd,
			output longint rn, output longint rd);
		longint g, den, num;
		g = longint'(gcd64(ad, bd));
		den = (ad / g) * bd;
		num = bn * (den / bd) + an * (den / ad);
		rn = 0;
		rd = 1;
		if (!fits(num) || !fits(den)) return ST_OVF;
		return reduce_frac(num, den, rn, rd);
	endfunction

	// multiply checks the unreduced products
	function automatic status_t mul_frac(longint an, longint ad, longint bn, longint bd,
			output longint rn, output longint rd);
		longint num, den;
		num = an * bn;
		den = ad * bd;
		rn = 0;
		rd = 1;
		if (!fits(num) || !fits(den)) return ST_OVF;
		return reduce_frac(num, den, rn, rd);
	endfunction

	function automatic frac_res_t predict_rational(op_t op);
		longint an, ad, bn, bd, rn, rd, xn, xd, q;
		longint unsigned r2;
		status_t st;
		frac_res_t r;
		an = longint'($signed(op.an));
		ad = longint'($signed(op.ad));
		bn = longint'($signed(op.bn));
		bd = longint'({33'd0, op.bd});
		rn = 0;
		rd = 1;
		st = reduce_frac(an, ad, an, ad);
		if (st == ST_OK && op.opc <= CMD_DIV) st = reduce_frac(bn, bd, bn, bd);
		if (st == ST_OK) begin
			case (op.opc)
				CMD_ADD: st = add_frac(an, ad, bn, bd, rn, rd);
				CMD_SUB: begin
					if (bn == LO) st = ST_OVF;
					else st = add_frac(an, ad, -bn, bd, rn, rd);
				end
				CMD_MUL: st = mul_frac(an, ad, bn, bd, rn, rd);
				CMD_DIV: begin
					st = reduce_frac(bd, bn, xn, xd);
					if (st == ST_OK) st = mul_frac(an, ad, xn, xd, rn, rd);
				end
				CMD_NEG: begin
					if (an == LO) st = ST_OVF;
					else begin
						rn = -an;
						rd = ad;
					end
				end
				CMD_RECIP: st = reduce_frac(ad, an, rn, rd);
				CMD_ROUND: begin
					// exact halves go toward zero
					q = an / ad;
					r2 = mag(an - q * ad) * 2;
					if (r2 > longint'(ad)) q += (an < 0) ? -1 : 1;
					rn = q;
					rd = 1;
					if (!fits(rn)) st = ST_OVF;
				end
				default: begin
					rn = an;
					rd = ad;
				end
			endcase
		end
		if (st != ST_OK) begin
			rn = 0;
			rd = 1;
		end
		r.num = rn[WB-1:0];
		r.den = rd[WB-2:0];
		r.st = st;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic logic [WB-1:0] pick_word();
		case ($urandom_range(0, 5))
			0: return WB'($signed($urandom_range(0, 40)) - 20);
			1: begin
				case ($urandom_range(0, 4))
					0: return W_MIN;
					1: return W_MAX;
					2: return '0;
					3: return 32'd1;
					default: return '1;
				endcase
			end
			2: return WB'($signed($urandom_range(0, 131072)) - 65536);
			3: return WB'($urandom_range(0, 4000)) * WB'($urandom_range(1, 30));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [WB-1:0] pick_den();
		logic [WB-1:0] v;
		v = pick_word();
		if ($urandom_range(0, 9) != 0) begin
			v[WB-1] = 1'b0;
			if (v == 0) v = 1;
		end
		return v;
	endfunction

	function automatic op_t random_op();
		op_t op;
		logic [WB-1:0] t;
		op.opc = cmd_t'($urandom_range(0, 7));
		op.an = pick_word();
		op.ad = pick_den();
		op.bn = pick_word();
		t = pick_den();
		op.bd = t[WB-2:0];
		if (op.bd == 0) op.bd = 1;
		return op;
	endfunction

	task automatic push_op(cmd_t c, logic [WB-1:0] an, ad, bn, logic [WB-2:0] bd);
		op_t op;
		op.opc = c;
		op.an = an;
		op.ad = ad;
		op.bn = bn;
		op.bd = bd;
		op_queue.push_back(op);
	endtask

	task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
		errors++;
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	// ---------------- input driver ----------------
	int src_gap = 0;
	always @(posedge clk) begin
		op_t op;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				op.opc = cmd_t'(cmd);
				op.an = a_num;
				op.ad = a_den;
				op.bn = b_num;
				op.bd = b_den;
				pending_results.push_back(predict_rational(op));
			end
			if (in_valid && in_stall) begin
				// stalled transaction holds
			end else if (src_gap > 0) begin
				in_valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				src_gap <= $urandom_range(0, 12);
			end else if (op_queue.size() > 0) begin
				op = op_queue.pop_front();
				in_valid <= 1'b1;
				cmd <= op.opc;
				a_num <= op.an;
				a_den <= op.ad;
				b_num <= op.bn;
				b_den <= op.bd;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------- output stall generator ----------------
	int stall_cnt = 0;
	int hold_seen = 0;
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			out_stall <= 1'b1;
			stall_cnt <= 400;
		end else if (stall_cnt > 0) begin
			out_stall <= 1'b1;
			stall_cnt <= stall_cnt - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_cnt <= $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------- result monitor ----------------
	always @(posedge clk) begin
		frac_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", res_num, '0);
			end else begin
				want = pending_results.pop_front();
				if (res_num !== want.num) report_mismatch("res_num", res_num, want.num);
				if (res_den !== want.den)
					report_mismatch("res_den", WB'(res_den), WB'(want.den));
				if (status !== want.st)
					report_mismatch("status", WB'(status), WB'(want.st));
			end
		end
	end

	// ---------------- watchdog ----------------
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// sampled at the falling edge, after the driver and monitor have settled
	task automatic wait_drained();
		while (op_queue.size() > 0 || in_valid || pending_results.size() > 0)
			@(negedge clk);
	endtask

	// ---------------- test sequence ----------------
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners
		push_op(CMD_ADD, W_MAX, 1, 1, 1);
		push_op(CMD_ADD, 32'd1, 32'd3, 32'd1, 31'd6);
		push_op(CMD_ADD, W_MIN, 1, W_MIN, 1);
		push_op(CMD_SUB, 32'd1, 32'd2, W_MIN, 31'd1);
		push_op(CMD_SUB, 32'd7, 32'd4, 32'd3, 31'd4);
		push_op(CMD_MUL, 32'h0001_0000, 1, 32'h0000_8000, 1);
		push_op(CMD_MUL, 32'd6, 32'd4, 32'd10, 31'd15);
		push_op(CMD_MUL, W_MAX, W_MAX, 32'd1, 31'h7FFF_FFFF);
		push_op(CMD_DIV, 32'd3, 32'd5, 32'd0, 31'd7);
		push_op(CMD_DIV, 32'd3, 32'd5, W_MIN, 31'd1);
		push_op(CMD_DIV, '1, 32'd2, 32'd2, 31'd9);
		push_op(CMD_NEG, W_MIN, 1, 0, 1);
		push_op(CMD_NEG, W_MAX, 32'd2, '1, 1);
		push_op(CMD_RECIP, 32'd0, 32'd5, 0, 1);
		push_op(CMD_RECIP, W_MIN, 1, 0, 1);
		push_op(CMD_RECIP, -32'sd7, 32'd3, 0, 1);
		push_op(CMD_ROUND, 32'd5, 32'd2, 0, 1);
		push_op(CMD_ROUND, -32'sd5, 32'd2, 0, 1);
		push_op(CMD_ROUND, -32'sd5, 32'd3, 0, 1);
		push_op(CMD_ROUND, W_MIN, 1, 0, 1);
		push_op(CMD_NORM, 32'd6, -32'sd4, 0, 1);
		push_op(CMD_NORM, 32'd6, 32'd0, 0, 1);
		push_op(CMD_NORM, W_MIN, '1, 0, 1);
		push_op(CMD_NORM, 32'd0, W_MIN, 0, 1);
		push_op(CMD_ADD, 32'd4, W_MIN, 32'd6, 31'd8);
		wait_drained();

		// random, with a long output hold-off while input keeps coming
		hold_seq = hold_seq + 1;
		repeat (600) op_queue.push_back(random_op());
		wait_drained();

		// sender paused above until all results returned
		repeat (500) op_queue.push_back(random_op());
		wait_drained();

		// closing stretch without idling
		quiet = 1;
		repeat (200) op_queue.push_back(random_op());
		wait_drained();

		repeat (50) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
